>>> rtl/core/sdrt_pkg.sv
package sdrt_pkg;

   // field widths
   localparam int VALUE_W = 32;   // Q15.16 stencil value
   localparam int CFG_W   = 32;   // widest CSR
   localparam int LEVEL_W = 5;
   localparam int LIMIT_W = 6;

   // intermediate widths (exact, no saturation)
   localparam int WIDE_W  = VALUE_W + 3;       // a, S2+2S1+S0
   localparam int MAG_W   = VALUE_W + 2;       // |a|, |b|
   localparam int DIFF_W  = VALUE_W + 1;       // |S2-S1|, |S1-S0|
   localparam int COEF_W  = 27;                // signed holder of 0.01 in Q0.32
   localparam int PROD_W  = WIDE_W + COEF_W;   // c * sum
   localparam int SCALE_W = PROD_W - 32;       // c * sum >> 32
   localparam int BSUM_W  = MAG_W + 2;         // b before magnitude
   localparam int CROSS_W = CFG_W + MAG_W;     // threshold * |b|
   localparam int FRAC_W  = 16;

   localparam int MAX_AXES = 3;
   localparam int DIMENSIONS_DEF = 3;

   localparam logic signed [COEF_W-1:0] COEF_Q32 = 27'sd42949673;

   // CSR map
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD     = 2'd0,
      CSR_FLOOR_VALUE   = 2'd1,
      CSR_LEVEL_CAP     = 2'd2,
      CSR_CURRENT_LEVEL = 2'd3
   } csr_index_type;

   localparam logic signed [LIMIT_W-1:0] LEVEL_CAP_RST = -6'sd1;

   // only one operation is defined
   localparam logic FUNC_EVALUATE = 1'b0;

   // per-stage advance enables inside the axis datapath
   typedef struct packed {
      logic a;
      logic b;
      logic c;
   } stage_en_type;

endpackage

>>> rtl/core/sdrt_req_if.sv
interface sdrt_req_if;
   import sdrt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] x_left;
   logic signed [VALUE_W-1:0] x_right;
   logic signed [VALUE_W-1:0] y_left;
   logic signed [VALUE_W-1:0] y_right;
   logic signed [VALUE_W-1:0] z_left;
   logic signed [VALUE_W-1:0] z_right;
   logic signed [VALUE_W-1:0] center_value;
   logic                      covered;
   logic                      already_tagged;
   logic                      func;

   modport source (
      output valid, x_left, x_right, y_left, y_right, z_left, z_right,
             center_value, covered, already_tagged, func,
      input  ready
   );

   modport sink (
      input  valid, x_left, x_right, y_left, y_right, z_left, z_right,
             center_value, covered, already_tagged, func,
      output ready
   );
endinterface

>>> rtl/core/sdrt_rsp_if.sv
interface sdrt_rsp_if;
   logic valid;
   logic ready;
   logic tag_set;

   modport source (
      output valid, tag_set,
      input  ready
   );

   modport sink (
      input  valid, tag_set,
      output ready
   );
endinterface

>>> rtl/core/sdrt_axis.sv
// One axis of the indicator: three register stages, fire flag out of the last.
module sdrt_axis (
   input  logic                                        clock,
   input  sdrt_pkg::stage_en_type                      stage_en,
   input  logic signed [sdrt_pkg::VALUE_W-1:0]         s0,
   input  logic signed [sdrt_pkg::VALUE_W-1:0]         s1,
   input  logic signed [sdrt_pkg::VALUE_W-1:0]         s2,
   input  logic        [sdrt_pkg::CFG_W-1:0]           threshold,
   input  logic        [sdrt_pkg::CFG_W-1:0]           floor_value,
   output logic                                        fires
);
   import sdrt_pkg::*;

   // stage A: differences, |a|, c*sum product
   logic signed [WIDE_W-1:0] s0_x, s1_x, s2_x;
   logic signed [WIDE_W-1:0] a_val, sum_val, dr, dl;
   logic        [MAG_W-1:0]  ma_in;
   logic        [DIFF_W-1:0] dr_mag_in, dl_mag_in;
   logic signed [PROD_W-1:0] prod_in;

   logic        [MAG_W-1:0]  ma_a_ff;
   logic        [DIFF_W-1:0] dr_mag_ff, dl_mag_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // stage B: rounding, b, |b|, floor test
   logic signed [PROD_W-1:0]  rnd;
   logic signed [SCALE_W-1:0] scaled;
   logic signed [BSUM_W-1:0]  b_val, b_neg;
   logic        [MAG_W-1:0]   mb_in;
   logic                      below_in;

   logic [MAG_W-1:0] ma_b_ff, mb_ff;
   logic             below_b_ff;

   // stage C: threshold * |b|
   logic [CROSS_W-1:0] cross_in;
   logic [CROSS_W-1:0] cross_ff;
   logic [MAG_W-1:0]   ma_c_ff;
   logic               below_c_ff;
   logic [CROSS_W-1:0] lhs;

   always_comb begin
      s0_x    = {{(WIDE_W-VALUE_W){s0[VALUE_W-1]}}, s0};
      s1_x    = {{(WIDE_W-VALUE_W){s1[VALUE_W-1]}}, s1};
      s2_x    = {{(WIDE_W-VALUE_W){s2[VALUE_W-1]}}, s2};
      a_val   = s2_x - (s1_x <<< 1) + s0_x;
      sum_val = s2_x + (s1_x <<< 1) + s0_x;
      dr      = s2_x - s1_x;
      dl      = s1_x - s0_x;
      ma_in     = a_val[WIDE_W-1] ? MAG_W'(-a_val) : MAG_W'(a_val);
      dr_mag_in = dr[WIDE_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
      dl_mag_in = dl[WIDE_W-1] ? DIFF_W'(-dl) : DIFF_W'(dl);
      prod_in = PROD_W'(sum_val * COEF_Q32);
   end

   always_ff @(posedge clock) begin
      if (stage_en.a) begin
         ma_a_ff   <= ma_in;
         dr_mag_ff <= dr_mag_in;
         dl_mag_ff <= dl_mag_in;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      // round to nearest, tie toward +inf: add half, then floor
      rnd    = prod_ff + (PROD_W'(1) <<< 31);
      scaled = rnd[PROD_W-1:32];
      b_val  = $signed({{(BSUM_W-DIFF_W){1'b0}}, dr_mag_ff})
             + $signed({{(BSUM_W-DIFF_W){1'b0}}, dl_mag_ff})
             + {{(BSUM_W-SCALE_W){scaled[SCALE_W-1]}}, scaled};
      b_neg  = -b_val;
      mb_in  = b_val[BSUM_W-1] ? b_neg[MAG_W-1:0] : b_val[MAG_W-1:0];
      below_in = mb_in <= {{(MAG_W-CFG_W){1'b0}}, floor_value};
   end

   always_ff @(posedge clock) begin
      if (stage_en.b) begin
         ma_b_ff    <= ma_a_ff;
         mb_ff      <= mb_in;
         below_b_ff <= below_in;
      end
   end

   assign cross_in = CROSS_W'(threshold) * CROSS_W'(mb_ff);

   always_ff @(posedge clock) begin
      if (stage_en.c) begin
         cross_ff   <= cross_in;
         ma_c_ff    <= ma_b_ff;
         below_c_ff <= below_b_ff;
      end
   end

   // |a| * 2^16 >= threshold * |b|
   assign lhs   = {{(CROSS_W-MAG_W-FRAC_W){1'b0}}, ma_c_ff, {FRAC_W{1'b0}}};
   assign fires = below_c_ff ? (threshold == '0) : (lhs >= cross_ff);

endmodule

>>> rtl/core/second_derivative_refine_tagger_core.sv
// Second-derivative refinement tagger, one cell per word.
// tag_set is registered: it leaves the result register at the end of the pipe.
// Throughput: one cell per cycle while rsp_bus is ready; set by 5 register
//   stages (input reg, three axis stages, result reg), each stalls on its own.
// Reset: synchronous, active high; clears all valid bits and loads CSR
//   defaults (threshold 0, floor 0, level cap -1, current_level 0).
module second_derivative_refine_tagger_core #(
   parameter int DIMENSIONS = sdrt_pkg::DIMENSIONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sdrt_req_if.sink                             req_bus,
   sdrt_rsp_if.source                           rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [sdrt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdrt_pkg::CFG_W-1:0]           csr_wr_data
);
   import sdrt_pkg::*;

   // values above 3 behave as 3
   localparam int AXES = (DIMENSIONS > MAX_AXES) ? MAX_AXES : DIMENSIONS;

   // ---------------- CSRs ----------------
   logic        [CFG_W-1:0]   threshold_ff, threshold_in;
   logic        [CFG_W-1:0]   floor_ff, floor_in;
   logic signed [LIMIT_W-1:0] level_cap_ff, level_cap_in;
   logic        [LEVEL_W-1:0] cur_level_ff, cur_level_in;

   always_comb begin
      threshold_in = threshold_ff;
      floor_in     = floor_ff;
      level_cap_in = level_cap_ff;
      cur_level_in = cur_level_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD:     threshold_in = csr_wr_data;
            CSR_FLOOR_VALUE:   floor_in     = csr_wr_data;
            CSR_LEVEL_CAP:     level_cap_in = $signed(csr_wr_data[LIMIT_W-1:0]);
            CSR_CURRENT_LEVEL: cur_level_in = csr_wr_data[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         floor_ff     <= '0;
         level_cap_ff <= LEVEL_CAP_RST;
         cur_level_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         floor_ff     <= floor_in;
         level_cap_ff <= level_cap_in;
         cur_level_ff <= cur_level_in;
      end
   end

   // tagging allowed: no limit, or current level strictly below the limit
   logic level_ok;
   assign level_ok = level_cap_ff[LIMIT_W-1] ||
                     ({1'b0, cur_level_ff} < $unsigned(level_cap_ff));

   // ---------------- stage valids / advance ----------------
   // Each stage moves when it is empty or the stage after it moves,
   // so bubbles collapse while the result word waits.
   logic v0_ff, va_ff, vb_ff, vc_ff, out_v_ff;
   logic v0_in, va_in, vb_in, vc_in, out_v_in;
   logic en_0, en_out;
   stage_en_type stage_en;

   always_comb begin
      en_out     = !out_v_ff || rsp_bus.ready;
      stage_en.c = !vc_ff || en_out;
      stage_en.b = !vb_ff || stage_en.c;
      stage_en.a = !va_ff || stage_en.b;
      en_0       = !v0_ff || stage_en.a;

      v0_in    = en_0       ? req_bus.valid : v0_ff;
      va_in    = stage_en.a ? v0_ff         : va_ff;
      vb_in    = stage_en.b ? va_ff         : vb_ff;
      vc_in    = stage_en.c ? vb_ff         : vc_ff;
      out_v_in = en_out     ? vc_ff         : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v0_ff    <= v0_in;
         va_ff    <= va_in;
         vb_ff    <= vb_in;
         vc_ff    <= vc_in;
         out_v_ff <= out_v_in;
      end
   end

   assign req_bus.ready = en_0;
   assign rsp_bus.valid = out_v_ff;

   // ---------------- input register ----------------
   logic signed [VALUE_W-1:0] left_ff  [MAX_AXES];
   logic signed [VALUE_W-1:0] right_ff [MAX_AXES];
   logic signed [VALUE_W-1:0] center_ff;
   logic covered_ff, tagged_ff, func_ff;

   always_ff @(posedge clock) begin
      if (en_0) begin
         left_ff[0]  <= req_bus.x_left;
         right_ff[0] <= req_bus.x_right;
         left_ff[1]  <= req_bus.y_left;
         right_ff[1] <= req_bus.y_right;
         left_ff[2]  <= req_bus.z_left;
         right_ff[2] <= req_bus.z_right;
         center_ff   <= req_bus.center_value;
         covered_ff  <= req_bus.covered;
         tagged_ff   <= req_bus.already_tagged;
         func_ff     <= req_bus.func;
      end
   end

   // pass-through cases: keep the incoming tag, no new one
   logic skip_0;
   assign skip_0 = tagged_ff || covered_ff || (func_ff != FUNC_EVALUATE) || !level_ok;

   // skip / tag bits ride alongside the axis stages
   logic skip_a_ff, skip_b_ff, skip_c_ff;
   logic tag_a_ff, tag_b_ff, tag_c_ff;

   always_ff @(posedge clock) begin
      if (stage_en.a) begin
         skip_a_ff <= skip_0;
         tag_a_ff  <= tagged_ff;
      end
      if (stage_en.b) begin
         skip_b_ff <= skip_a_ff;
         tag_b_ff  <= tag_a_ff;
      end
      if (stage_en.c) begin
         skip_c_ff <= skip_b_ff;
         tag_c_ff  <= tag_b_ff;
      end
   end

   // ---------------- per-axis datapaths ----------------
   logic [AXES-1:0] axis_fires;

   for (genvar d = 0; d < AXES; d++) begin : g_axis
      sdrt_axis u_axis (
         .clock       (clock),
         .stage_en    (stage_en),
         .s0          (left_ff[d]),
         .s1          (center_ff),
         .s2          (right_ff[d]),
         .threshold   (threshold_ff),
         .floor_value (floor_ff),
         .fires       (axis_fires[d])
      );
   end

   // ---------------- result register ----------------
   logic tag_ff, tag_in;

   assign tag_in = skip_c_ff ? tag_c_ff : (|axis_fires);

   always_ff @(posedge clock) begin
      if (en_out) begin
         tag_ff <= tag_in;
      end
   end

   assign rsp_bus.tag_set = tag_ff;

endmodule

>>> tb/sv/sdrt_tag_scoreboard_pkg.sv
`timescale 1ns / 100ps

package sdrt_tag_scoreboard_pkg;
   import sdrt_pkg::*;

   localparam logic FUNC_UNDEFINED = ~FUNC_EVALUATE;

   typedef struct {
      logic signed [VALUE_W-1:0] x_left;
      logic signed [VALUE_W-1:0] x_right;
      logic signed [VALUE_W-1:0] y_left;
      logic signed [VALUE_W-1:0] y_right;
      logic signed [VALUE_W-1:0] z_left;
      logic signed [VALUE_W-1:0] z_right;
      logic signed [VALUE_W-1:0] center_value;
      logic                      covered;
      logic                      already_tagged;
      logic                      func;
   } cell_word_type;

   class refine_tag_board;
      // 0.01 in unsigned Q0.32
      localparam longint DAMP_Q32 = 42949673;

      bit [CFG_W-1:0]              threshold;
      bit [CFG_W-1:0]              floor_value;
      logic signed [LIMIT_W-1:0]   level_cap;
      bit [LEVEL_W-1:0]            current_level;
      bit                          expected_tags[$];
      int                          mismatch_count;

      function new();
         threshold      = '0;
         floor_value    = '0;
         level_cap      = LEVEL_CAP_RST;
         current_level  = '0;
         mismatch_count = 0;
      endfunction

      function void set_reg(csr_index_type idx, bit [CFG_W-1:0] data);
         case (idx)
            CSR_THRESHOLD:     threshold     = data;
            CSR_FLOOR_VALUE:   floor_value   = data;
            CSR_LEVEL_CAP:     level_cap     = data[LIMIT_W-1:0];
            CSR_CURRENT_LEVEL: current_level = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_tags.size();
      endfunction

      // one axis: |a| * 2^16 >= threshold * |b|, exact in 128 bits
      function bit axis_fires(longint s0, longint s1, longint s2);
         longint     a_val;
         longint     sum;
         longint     damped;
         longint     b_val;
         bit [63:0]  mag_a;
         bit [63:0]  mag_b;
         bit [127:0] lhs;
         bit [127:0] rhs;
         a_val  = s2 - 2 * s1 + s0;
         sum    = s2 + 2 * s1 + s0;
         damped = (sum * DAMP_Q32 + 64'sd2147483648) >>> 32;
         b_val  = ((s2 > s1) ? s2 - s1 : s1 - s2) + ((s1 > s0) ? s1 - s0 : s0 - s1) + damped;
         mag_a  = (a_val < 0) ? -a_val : a_val;
         mag_b  = (b_val < 0) ? -b_val : b_val;
         if (mag_b <= {32'b0, floor_value})
            return threshold == 0;
         lhs = {64'b0, mag_a} << FRAC_W;
         rhs = {96'b0, threshold} * {64'b0, mag_b};
         return lhs >= rhs;
      endfunction

      function bit predict_tag(cell_word_type w);
         int lim;
         int lvl;
         bit enabled;
         lim     = level_cap;
         lvl     = current_level;
         enabled = (lim < 0) || (lvl < lim);
         if (w.already_tagged || w.covered || w.func != FUNC_EVALUATE || !enabled)
            return w.already_tagged;
         return axis_fires(w.x_left, w.center_value, w.x_right)
             || axis_fires(w.y_left, w.center_value, w.y_right)
             || axis_fires(w.z_left, w.center_value, w.z_right);
      endfunction

      function void note_cell(cell_word_type w);
         expected_tags.insert(expected_tags.size(), predict_tag(w));
      endfunction

      function void check_tag(bit got);
         bit want;
         if (expected_tags.size() == 0) begin
            $error("tag_set: expected none, actual %0b", got);
            mismatch_count++;
            return;
         end
         want = expected_tags.pop_front();
         if (want != got) begin
            $error("tag_set: expected %0b, actual %0b", want, got);
            mismatch_count++;
         end
      endfunction
   endclass

endpackage

>>> tb/sv/second_derivative_refine_tagger_core_tb.sv
`timescale 1ns / 100ps

module second_derivative_refine_tagger_core_tb;
   import sdrt_pkg::*;
   import sdrt_tag_scoreboard_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int LONG_HOLD    = 250;   // rsp stall that fills the pipe
   localparam int PHASE_CELLS  = 100;   // evaluated cells per random phase
   localparam int RANDOM_PHASES = 8;
   localparam int TAIL_CYCLES  = 16;    // pipe is 5 deep, plenty of margin

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CFG_W-1:0]     csr_wr_data = '0;

   sdrt_req_if req_bus ();
   sdrt_rsp_if rsp_bus ();

   refine_tag_board board = new();

   // calm and hold_request are shared between the req driver and the rsp sink
   bit calm         = 1'b0;   // no idling on either side
   bit hold_request = 1'b0;   // ask the sink for one long stall
   int cycle_count  = 0;

   second_derivative_refine_tagger_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_extreme();
      logic signed [VALUE_W-1:0] pool[6];
      pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
               32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};
      return pool[$urandom_range(0, 5)];
   endfunction

   function automatic cell_word_type make_cell(
      logic signed [VALUE_W-1:0] xl, logic signed [VALUE_W-1:0] xr,
      logic signed [VALUE_W-1:0] yl, logic signed [VALUE_W-1:0] yr,
      logic signed [VALUE_W-1:0] zl, logic signed [VALUE_W-1:0] zr,
      logic signed [VALUE_W-1:0] ctr,
      logic cov, logic tag, logic fn);
      cell_word_type w;
      w.x_left = xl;  w.x_right = xr;
      w.y_left = yl;  w.y_right = yr;
      w.z_left = zl;  w.z_right = zr;
      w.center_value   = ctr;
      w.covered        = cov;
      w.already_tagged = tag;
      w.func           = fn;
      return w;
   endfunction

   // Mostly smooth neighborhoods of random scale, so the indicator lands on
   // both sides of realistic thresholds; some raw noise, extremes and spikes.
   function automatic cell_word_type random_cell();
      cell_word_type             w;
      logic signed [VALUE_W-1:0] base;
      logic signed [VALUE_W-1:0] delta;
      logic signed [VALUE_W-1:0] pts[6];
      int                        mode;
      mode = $urandom_range(0, 9);
      base = $urandom();
      base = base >>> $urandom_range(0, 20);
      for (int i = 0; i < 6; i++) begin
         case (mode)
            0, 1: pts[i] = $urandom();
            8:    pts[i] = pick_extreme();
            default: begin
               delta  = $urandom();
               pts[i] = base + (delta >>> $urandom_range(6, 30));
            end
         endcase
      end
      if (mode == 8)
         base = pick_extreme();
      if (mode == 9) begin
         delta = $urandom();
         base  = base + (delta >>> $urandom_range(4, 16));
      end
      w = make_cell(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5], base,
                    $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                    ($urandom_range(0, 11) == 0) ? FUNC_UNDEFINED : FUNC_EVALUATE);
      return w;
   endfunction

   // offer one word, hold it until taken; valid only drops if a gap follows
   task automatic send_cell(cell_word_type w);
      int gap;
      req_bus.valid          <= 1'b1;
      req_bus.x_left         <= w.x_left;
      req_bus.x_right        <= w.x_right;
      req_bus.y_left         <= w.y_left;
      req_bus.y_right        <= w.y_right;
      req_bus.z_left         <= w.z_left;
      req_bus.z_right        <= w.z_right;
      req_bus.center_value   <= w.center_value;
      req_bus.covered        <= w.covered;
      req_bus.already_tagged <= w.already_tagged;
      req_bus.func           <= w.func;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_cell(w);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding tag
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // all four CSRs back to back, only with the pipe empty
   task automatic program_regs(bit [CFG_W-1:0] thr, bit [CFG_W-1:0] flo,
                               logic signed [LIMIT_W-1:0] ml,
                               bit [LEVEL_W-1:0] cl);
      bit [CFG_W-1:0] vals[4];
      csr_index_type  idx;
      wait_drained();
      vals = '{thr, flo, {{(CFG_W-LIMIT_W){1'b0}}, ml},
               {{(CFG_W-LEVEL_W){1'b0}}, cl}};
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         csr_wr_en   <= 1'b1;
         csr_index   <= idx;
         csr_wr_data <= vals[i];
         board.set_reg(idx, vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // rsp sink: checks every taken word, idles at random, one long hold on request
   initial begin
      int idle_left;
      int hold_left;
      idle_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_tag(rsp_bus.tag_set);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            idle_left = calm ? 0 : pick_gap();
         end
      end
   end

   // stimulus
   initial begin
      bit [CFG_W-1:0]            thr;
      bit [CFG_W-1:0]            flo;
      logic signed [LIMIT_W-1:0] ml;
      bit [LEVEL_W-1:0]          cl;
      cell_word_type             w;
      int                        done;
      int                        r;

      req_bus.valid          = 1'b0;
      req_bus.x_left         = '0;
      req_bus.x_right        = '0;
      req_bus.y_left         = '0;
      req_bus.y_right        = '0;
      req_bus.z_left         = '0;
      req_bus.z_right        = '0;
      req_bus.center_value   = '0;
      req_bus.covered        = 1'b0;
      req_bus.already_tagged = 1'b0;
      req_bus.func           = FUNC_EVALUATE;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset CSRs: zero threshold tags every evaluated cell
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, FUNC_EVALUATE));   // b == 0
      send_cell(make_cell('1 >>> 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          0, 0, FUNC_EVALUATE));
      send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 1, 0, FUNC_EVALUATE));   // covered
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 1, FUNC_EVALUATE));   // pre-tagged
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, FUNC_UNDEFINED));

      // --- directed, threshold 0.5, small floor
      program_regs(32'h0000_8000, 32'h0000_0100, -6'sd1, 5'd0);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, FUNC_EVALUATE));   // floored
      send_cell(make_cell(32'h0000_F000, 32'h0001_1000, 32'h0000_F000,   // linear, a == 0
                          32'h0001_1000, 32'h0000_F000, 32'h0001_1000,
                          32'h0001_0000, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE)); // spike
      send_cell(make_cell(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,   // z axis only
                          32'h0002_0000, 32'h0005_0000, 32'h0002_0000,
                          32'h0002_0000, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 0, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 1, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_UNDEFINED));

      // --- everything floored: nonzero threshold never fires, zero always does
      program_regs('1, '1, -6'sd1, 5'd0);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));
      program_regs(32'h0, '1, -6'sd1, 5'd0);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));

      // --- level limit
      program_regs(32'h0000_8000, 32'h0, 6'sd5, 5'd5);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 1, FUNC_EVALUATE));
      program_regs(32'h0000_8000, 32'h0, 6'sd5, 5'd4);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));
      program_regs(32'h0000_8000, 32'h0, 6'sd31, 5'd31);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));
      program_regs(32'h0000_8000, 32'h0, 6'sd0, 5'd0);
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, FUNC_EVALUATE));

      // --- random phases; the first few pin the CSR extremes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         r = $urandom_range(0, 9);
         thr = (r == 0) ? 32'h0 : (r == 1) ? '1 : (r == 2) ? 32'($urandom())
             : 32'($urandom_range(0, 32'h0001_8000));
         r = $urandom_range(0, 9);
         flo = (r == 0) ? '1 : (r == 1) ? 32'($urandom())
             : (r < 6) ? 32'($urandom_range(0, 32'h0004_0000)) : 32'h0;
         r = $urandom_range(0, 9);
         ml = (r < 5) ? -6'sd1 : (r == 5) ? 6'sd0 : (r == 6) ? 6'sd31
            : 6'($urandom_range(0, 31));
         r = $urandom_range(0, 9);
         cl = (r < 6) ? 5'd0 : (r == 6) ? 5'd31 : 5'($urandom_range(0, 31));
         case (p)
            0: begin thr = '1; flo = 32'h0; ml = 6'sd31; cl = 5'd0; end
            1: begin thr = 32'($urandom_range(0, 32'h0001_8000)); flo = '1; end
            2: begin ml = 6'sd0; cl = 5'd31; end
            3: begin ml = -6'sd1; cl = 5'd31; end
            default: ;
         endcase
         program_regs(thr, flo, ml, cl);
         calm = (p == 1);
         // sink stalls long while cells keep coming: pipe fills, req stalls
         if (p == 4)
            hold_request = 1'b1;
         done = 0;
         while (done < PHASE_CELLS) begin
            w = random_cell();
            send_cell(w);
            if (w.func == FUNC_EVALUATE)
               done++;
            // sender pauses until the pipe has drained
            if (p == 5 && done == PHASE_CELLS / 2 && w.func == FUNC_EVALUATE)
               wait_drained();
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sdrt_pkg.sv
rtl/core/sdrt_req_if.sv
rtl/core/sdrt_rsp_if.sv
rtl/core/sdrt_axis.sv
rtl/core/second_derivative_refine_tagger_core.sv
tb/sv/sdrt_tag_scoreboard_pkg.sv
tb/sv/second_derivative_refine_tagger_core_tb.sv
